/* hw/rtl/traffic_loop_record_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Traffic loop record decoder assertion macros
// Assertion forms used by the decoder's controller.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LOOP_RECORD_DECODER_ASSERT_SVH
`define TRAFFIC_LOOP_RECORD_DECODER_ASSERT_SVH

// Same-cycle implication under reset.
`define TLRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("traffic loop decoder check failed");

// Next-cycle implication under reset.
`define TLRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("traffic loop decoder check failed");

`endif

/* hw/rtl/tlrd_pkg.sv */
// ----------------------------------------------------------------------------
// Traffic loop record decoder package
// Word types, constants and control types shared by the decoder modules.
// ----------------------------------------------------------------------------
package tlrd_pkg;

   localparam int HeaderLen     = 10;
   localparam int RecordLen     = 5;
   localparam int CheckPos      = 4;
   localparam int DividendWidth = 29;
   localparam int DivisorWidth  = 14;
   localparam int DivSteps      = DividendWidth;
   localparam int StepWidth     = $clog2(DivSteps);
   localparam int OccWidth      = 12;
   localparam int OccShift      = 17;

   localparam logic [12:0] SpeedScale = 13'd4800;
   localparam logic [15:0] ThirdRecip = 16'hAAAB;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef enum logic {
      KIND_RECORD = 1'b0,
      KIND_ERROR  = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [0:0]  result_kind;
      logic [15:0] record_index;
      logic [1:0]  incident_code;
      logic        data_valid;
      logic [2:0]  loop_count;
      logic [10:0] scan_count;
      logic [11:0] occupancy_q4;
      logic [15:0] volume;
      logic [28:0] speed_q4;
      logic        speed_undefined;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_RECORDS = 2'd1,
      MODE_IGNORE  = 2'd2
   } parse_mode_type;

   typedef struct packed {
      logic       store_byte;
      logic [1:0] store_index;
      logic       start_record;
      logic       start_error;
      logic       count_clear;
      logic       mul_load;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic hdr_ok;
      logic out_busy;
   } sts_type;

endpackage

/* hw/rtl/tlrd_ctrl.sv */
// ----------------------------------------------------------------------------
// Traffic loop record decoder controller
// Tracks the file parse position and sequences each record's arithmetic.
// ----------------------------------------------------------------------------
`include "traffic_loop_record_decoder_assert.svh"

module tlrd_ctrl
   import tlrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type       state_ff, state_in;
   parse_mode_type       mode_ff, mode_in;
   logic [3:0]           pos_ff, pos_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_HEADER;
         pos_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.store_index = pos_ff[1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_ff)
                  MODE_HEADER: begin
                     if (pos_ff == 4'(CheckPos) && !sts.hdr_ok) begin
                        cmd.start_error = 1'b1;
                        mode_in  = MODE_IGNORE;
                        state_in = ST_DONE;
                     end else if (pos_ff == 4'(HeaderLen - 1)) begin
                        mode_in = MODE_RECORDS;
                        pos_in  = '0;
                     end else begin
                        pos_in = pos_ff + 4'd1;
                     end
                  end
                  MODE_RECORDS: begin
                     if (pos_ff < 4'(RecordLen - 1)) begin
                        cmd.store_byte = 1'b1;
                        pos_in = pos_ff + 4'd1;
                     end else begin
                        if (!req_last) begin
                           cmd.start_record = 1'b1;
                           state_in = ST_MUL;
                        end
                        pos_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               if (req_last) begin
                  pos_in          = '0;
                  mode_in         = MODE_HEADER;
                  cmd.count_clear = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + StepWidth'(1);
            if (step_ff == StepWidth'(DivSteps - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `TLRD_ASSERT_NOW(a_step_range, clock, reset, state_ff == ST_DIV,
                    step_ff < StepWidth'(DivSteps))
   `TLRD_ASSERT_NEXT(a_record_starts_mul, clock, reset, cmd.start_record,
                     state_ff == ST_MUL)
   `TLRD_ASSERT_NEXT(a_done_to_idle, clock, reset, cmd.out_load,
                     state_ff == ST_IDLE && !req_stall)

endmodule

/* hw/rtl/tlrd_dp.sv */
// ----------------------------------------------------------------------------
// Traffic loop record decoder datapath
// Record byte store, record counter, products, serial divider and result word.
// ----------------------------------------------------------------------------
module tlrd_dp
   import tlrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0]               rec_ff [4];
   logic [15:0]              vol_ff;
   logic [15:0]              index_ff;
   logic [15:0]              count_ff, count_in;
   logic                     err_ff;
   logic [DividendWidth-1:0] quo_ff, quo_in;
   logic [DivisorWidth-1:0]  rem_ff, rem_in;
   logic [DivisorWidth-1:0]  divisor_ff;
   logic [OccWidth-1:0]      occ_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [2:0]               loops;
   logic [10:0]              scan;
   logic [12:0]              scan_x4;
   logic [28:0]              occ_prod;
   logic [DividendWidth-1:0] dividend;
   logic [DivisorWidth:0]    rem_shift;
   logic                     fits;

   assign loops    = rec_ff[1][6:4];
   assign scan     = {rec_ff[1][2:0], rec_ff[2]};
   assign scan_x4  = {scan, 2'b00};
   assign occ_prod = 29'(scan_x4) * 29'(ThirdRecip);
   assign dividend = DividendWidth'(SpeedScale) * DividendWidth'(vol_ff);

   assign rem_shift = {rem_ff, quo_ff[DividendWidth-1]};
   assign fits      = (rem_shift >= {1'b0, divisor_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mul_load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (cmd.div_step) begin
         rem_in = fits ? DivisorWidth'(rem_shift - {1'b0, divisor_ff})
                       : DivisorWidth'(rem_shift);
         quo_in = {quo_ff[DividendWidth-2:0], fits};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.start_record && count_ff != 16'hFFFF) begin
         count_in = count_ff + 16'd1;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (err_ff) begin
         rsp_in.result_kind = KIND_ERROR;
      end else begin
         rsp_in.result_kind     = KIND_RECORD;
         rsp_in.record_index    = index_ff;
         rsp_in.incident_code   = rec_ff[0][7:6];
         rsp_in.data_valid      = rec_ff[1][7];
         rsp_in.loop_count      = loops;
         rsp_in.scan_count      = scan;
         rsp_in.occupancy_q4    = occ_ff;
         rsp_in.volume          = vol_ff;
         rsp_in.speed_undefined = (divisor_ff == '0);
         rsp_in.speed_q4        = (divisor_ff == '0) ? '0 : quo_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         rec_ff[cmd.store_index] <= req_data.data_byte;
      end
      if (cmd.start_record) begin
         vol_ff   <= {rec_ff[3], req_data.data_byte};
         index_ff <= count_ff;
         err_ff   <= 1'b0;
      end
      if (cmd.start_error) begin
         err_ff <= 1'b1;
      end
      if (cmd.mul_load) begin
         divisor_ff <= DivisorWidth'(loops) * DivisorWidth'(scan);
         occ_ff     <= occ_prod[OccShift +: OccWidth];
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.hdr_ok   = !req_data.data_byte[7] && (req_data.data_byte[6:1] != '0);
   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

/* hw/rtl/traffic_loop_record_decoder.sv */
// ----------------------------------------------------------------------------
// Traffic loop record decoder
// Decodes a traffic-loop data file, one byte per word, into record results.
// ----------------------------------------------------------------------------
// The req channel carries one file byte per word, with last_byte set on the
// final byte of a file. The rsp channel carries one result word per decoded
// record, or a single error word when header byte 4 is out of range.
// Header bytes other than a bad check byte, record bytes 0 to 3 and ignored
// bytes are taken without stalling the input. The fifth byte of a record starts
// a product step and a restoring divider that produces one speed bit per cycle;
// the result is then loaded into the output register, and the input stalls until it is.
// An error word goes through ST_DONE into the output register after the
// bad header byte is accepted.
// The result sits in an output register; further bytes are accepted while
// it waits, but the next result is held until the register is taken.
// While rsp_stall is high the result word holds steady.
// Reset returns the parser to the start of a header, clears the record
// counter and empties the output register.
// ----------------------------------------------------------------------------
module traffic_loop_record_decoder
   import tlrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   tlrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_byte),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlrd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/tb_traffic_loop_record_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Traffic loop record decoder testbench
// Streams traffic-loop data files into the decoder one byte per word and
// checks every result word against a cycle-free model of the parser. A
// short directed set is followed by random files, mostly well formed,
// under phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_traffic_loop_record_decoder;
   import tlrd_pkg::*;

   localparam int CycleLimit  = 500000;
   localparam int PhaseWords  = 175;
   localparam int TailCycles  = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type predicted_results[$];

   int send_idle_plan[4] = '{0, 60, 0, 11};
   int stall_plan[4]     = '{0, 0, 60, 11};
   int send_idle_pct;
   int stall_pct;

   int cycle_count;
   int failure_count;
   int files_queued;
   int words_queued;
   int records_checked;
   int errors_checked;

   logic [3:0]     byte_pos;
   parse_mode_type cur_mode;
   logic [7:0]     rec_store[4];
   logic [15:0]    rec_number;

   traffic_loop_record_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task decode_byte(input req_type w);
      rsp_type     r;
      logic [2:0]  loops;
      logic [10:0] scan;
      logic [15:0] vol;
      logic [31:0] divisor;
      logic [31:0] occ_full;
      logic [63:0] speed_full;
      r = '0;
      case (cur_mode)
         MODE_HEADER: begin
            if (byte_pos == CheckPos && (w.data_byte < 8'd2 || w.data_byte > 8'd127)) begin
               r.result_kind = KIND_ERROR;
               predicted_results.push_back(r);
               cur_mode = MODE_IGNORE;
            end else if (byte_pos == HeaderLen - 1) begin
               cur_mode = MODE_RECORDS;
               byte_pos = '0;
            end else begin
               byte_pos++;
            end
         end
         MODE_RECORDS: begin
            if (byte_pos < RecordLen - 1) begin
               rec_store[byte_pos[1:0]] = w.data_byte;
               byte_pos++;
            end else begin
               if (!w.last_byte) begin
                  loops = rec_store[1][6:4];
                  scan = {rec_store[1][2:0], rec_store[2]};
                  vol = {rec_store[3], w.data_byte};
                  divisor = loops * scan;
                  occ_full = {21'd0, scan} * 32'd4 / 32'd3;
                  speed_full = (divisor == 0) ? 64'd0 : 64'd4800 * vol / divisor;
                  r.result_kind = KIND_RECORD;
                  r.record_index = rec_number;
                  r.incident_code = rec_store[0][7:6];
                  r.data_valid = rec_store[1][7];
                  r.loop_count = loops;
                  r.scan_count = scan;
                  r.occupancy_q4 = occ_full[11:0];
                  r.volume = vol;
                  r.speed_q4 = speed_full[28:0];
                  r.speed_undefined = (divisor == 0);
                  predicted_results.push_back(r);
                  if (rec_number != 16'hFFFF) begin
                     rec_number++;
                  end
               end
               byte_pos = '0;
            end
         end
         default: begin
         end
      endcase
      if (w.last_byte) begin
         byte_pos = '0;
         cur_mode = MODE_HEADER;
         rec_number = '0;
      end
   endtask

   task report_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task check_result(input rsp_type got);
      rsp_type want;
      string   bad_fields;
      if (predicted_results.size() == 0) begin
         report_failure($sformatf("unexpected result word %h", got));
         return;
      end
      want = predicted_results.pop_front();
      bad_fields = "";
      if (got.result_kind != want.result_kind) bad_fields = {bad_fields, " result_kind"};
      if (got.record_index != want.record_index) bad_fields = {bad_fields, " record_index"};
      if (got.incident_code != want.incident_code) bad_fields = {bad_fields, " incident_code"};
      if (got.data_valid != want.data_valid) bad_fields = {bad_fields, " data_valid"};
      if (got.loop_count != want.loop_count) bad_fields = {bad_fields, " loop_count"};
      if (got.scan_count != want.scan_count) bad_fields = {bad_fields, " scan_count"};
      if (got.occupancy_q4 != want.occupancy_q4) bad_fields = {bad_fields, " occupancy_q4"};
      if (got.volume != want.volume) bad_fields = {bad_fields, " volume"};
      if (got.speed_q4 != want.speed_q4) bad_fields = {bad_fields, " speed_q4"};
      if (got.speed_undefined != want.speed_undefined) begin
         bad_fields = {bad_fields, " speed_undefined"};
      end
      if (bad_fields != "") begin
         report_failure($sformatf("mismatch in%s: expected %h, got %h", bad_fields, want, got));
      end
      if (want.result_kind == KIND_ERROR) begin
         errors_checked++;
      end else begin
         records_checked++;
      end
   endtask

   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'h00;
      if (roll < 20) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_check_byte(input bit good);
      if (good) return 8'($urandom_range(127, 2));
      case ($urandom_range(2))
         0: return 8'h00;
         1: return 8'h01;
         default: return 8'($urandom_range(255, 128));
      endcase
   endfunction

   task automatic queue_file(input logic [7:0] file_bytes[$]);
      req_type w;
      foreach (file_bytes[i]) begin
         w.data_byte = file_bytes[i];
         w.last_byte = (i == file_bytes.size() - 1);
         pending_words.push_back(w);
      end
      files_queued++;
      words_queued += file_bytes.size();
   endtask

   task automatic queue_random_file();
      logic [7:0] file_bytes[$];
      int shape;
      int keep;
      bit good;
      shape = $urandom_range(99);
      good = (shape >= 25) || (shape < 15 && shape % 2 == 0);
      if (shape < 8) begin
         repeat ($urandom_range(14, 1)) file_bytes.push_back(8'($urandom_range(255)));
      end else begin
         for (int i = 0; i < HeaderLen; i++) begin
            file_bytes.push_back(i == CheckPos ? pick_check_byte(good) : 8'($urandom_range(255)));
         end
         if (shape < 15) begin
            keep = $urandom_range(HeaderLen - 1, 1);
         end else if (shape < 25) begin
            keep = CheckPos + 1 + $urandom_range(HeaderLen - CheckPos - 1);
         end else begin
            keep = HeaderLen;
            repeat ($urandom_range(6) * RecordLen) file_bytes.push_back(pick_byte());
            repeat ($urandom_range(4)) file_bytes.push_back(pick_byte());
         end
         while (file_bytes.size() > keep && shape < 25) file_bytes.pop_back();
      end
      queue_file(file_bytes);
   endtask

   task wait_until_drained();
      while (pending_words.size() != 0 || req_valid || predicted_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Run stopped at the cycle limit with %0d results outstanding.",
                  predicted_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] directed[$];
      int         target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      byte_pos = '0;
      cur_mode = MODE_HEADER;
      rec_number = '0;
      rec_store = '{default: 8'h00};

      // A file that ends on a negative check byte, then one with the largest
      // good check byte, an all-ones record, an all-zero record and a
      // trailing partial record.
      directed = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h80};
      queue_file(directed);
      directed = '{8'hA5, 8'h5A, 8'h01, 8'h02, 8'h7F, 8'hFE, 8'h00, 8'h80, 8'h40, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h5A, 8'hA5, 8'hC3};
      queue_file(directed);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_plan[phase];
         stall_pct = stall_plan[phase];
         target = words_queued + PhaseWords;
         while (words_queued < target) queue_random_file();
         wait_until_drained();
      end

      repeat (TailCycles) @(posedge clock);
      $display("Sent %0d byte words in %0d files over four idle and stall phases.",
               words_queued, files_queued);
      $display("Checked %0d record words and %0d no-data error words.",
               records_checked, errors_checked);
      if (failure_count == 0 && predicted_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
